[hw/rtl/slt_pkg.sv]
// slt_pkg: shared types, codes, character constants and decode functions
// for the source line tokenizer. No dependencies; used by every slt module.

package slt_pkg;

	localparam int MAX_COLUMN_DEFAULT = 1023;
	localparam int MAX_LINE_DEFAULT   = 65535;
	localparam int QUEUE_DEPTH        = 4;

	localparam logic [9:0] LEN_CAP = 10'd1023;

	typedef enum logic [1:0] {
		PC_NONE,
		PC_WORD,
		PC_NUM,
		PC_OP
	} pend_class_t;

	localparam logic [1:0] ERR_NONE        = 2'd0;
	localparam logic [1:0] ERR_DIGIT_ALPHA = 2'd1;
	localparam logic [1:0] ERR_BAD_CHAR    = 2'd2;

	localparam logic [4:0] TK_LITERAL = 5'd0;
	localparam logic [4:0] TK_IDENT   = 5'd1;
	localparam logic [4:0] TK_PRINT   = 5'd2;
	localparam logic [4:0] TK_I32     = 5'd3;
	localparam logic [4:0] TK_BOOL    = 5'd4;
	localparam logic [4:0] TK_TRUE    = 5'd5;
	localparam logic [4:0] TK_FALSE   = 5'd6;
	localparam logic [4:0] TK_DIV     = 5'd7;
	localparam logic [4:0] TK_ASSIGN  = 5'd8;
	localparam logic [4:0] TK_EQ      = 5'd9;
	localparam logic [4:0] TK_NOT     = 5'd10;
	localparam logic [4:0] TK_NE      = 5'd11;
	localparam logic [4:0] TK_LT      = 5'd12;
	localparam logic [4:0] TK_LE      = 5'd13;
	localparam logic [4:0] TK_GT      = 5'd14;
	localparam logic [4:0] TK_GE      = 5'd15;
	localparam logic [4:0] TK_AND     = 5'd16;
	localparam logic [4:0] TK_OR      = 5'd17;
	localparam logic [4:0] TK_PLUS    = 5'd18;
	localparam logic [4:0] TK_MINUS   = 5'd19;
	localparam logic [4:0] TK_STAR    = 5'd20;
	localparam logic [4:0] TK_SEMI    = 5'd21;
	localparam logic [4:0] TK_LPAREN  = 5'd22;
	localparam logic [4:0] TK_RPAREN  = 5'd23;
	localparam logic [4:0] TK_LBRACE  = 5'd24;
	localparam logic [4:0] TK_RBRACE  = 5'd25;

	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_PIPE   = 8'h7c;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_UNDER  = 8'h5f;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;

	localparam logic [39:0] KW_PRINT = 40'h746e697270;
	localparam logic [39:0] KW_I32   = 40'h0000323369;
	localparam logic [39:0] KW_BOOL  = 40'h006c6f6f62;
	localparam logic [39:0] KW_TRUE  = 40'h0065757274;
	localparam logic [39:0] KW_FALSE = 40'h65736c6166;

	typedef struct packed {
		logic [4:0]  kind;
		logic [1:0]  err;
		logic [7:0]  bad;
		logic [15:0] line;
		logic [9:0]  loc;
		logic [9:0]  start;
		logic [9:0]  len;
	} tok_t;

	typedef struct packed {
		logic two;
		tok_t first;
		tok_t second;
	} bundle_t;

	typedef struct packed {
		logic    avail;
		bundle_t bundle;
	} qhead_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic is_op_start(input logic [7:0] c);
		logic r;
		case (c) inside
			CH_SLASH, CH_EQ, CH_BANG, CH_LT, CH_GT, CH_AMP, CH_PIPE: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// TK_LITERAL means the byte is not a single-character token
	function automatic logic [4:0] single_kind(input logic [7:0] c);
		logic [4:0] k;
		unique case (c)
			CH_PLUS:   k = TK_PLUS;
			CH_MINUS:  k = TK_MINUS;
			CH_STAR:   k = TK_STAR;
			CH_SEMI:   k = TK_SEMI;
			CH_LPAREN: k = TK_LPAREN;
			CH_RPAREN: k = TK_RPAREN;
			CH_LBRACE: k = TK_LBRACE;
			CH_RBRACE: k = TK_RBRACE;
			default:   k = TK_LITERAL;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] keyword_kind(input logic [39:0] prefix, input logic [9:0] len);
		logic [4:0] k;
		if (len == 10'd5 && prefix == KW_PRINT) k = TK_PRINT;
		else if (len == 10'd3 && prefix == KW_I32) k = TK_I32;
		else if (len == 10'd4 && prefix == KW_BOOL) k = TK_BOOL;
		else if (len == 10'd4 && prefix == KW_TRUE) k = TK_TRUE;
		else if (len == 10'd5 && prefix == KW_FALSE) k = TK_FALSE;
		else k = TK_IDENT;
		return k;
	endfunction

	// one-character kind in [9:5], two-character kind in [4:0]
	function automatic logic [9:0] op_kinds(input logic [7:0] p);
		logic [9:0] r;
		unique case (p)
			CH_EQ:   r = {TK_ASSIGN, TK_EQ};
			CH_BANG: r = {TK_NOT, TK_NE};
			CH_LT:   r = {TK_LT, TK_LE};
			CH_AMP:  r = {TK_LITERAL, TK_AND};
			CH_PIPE: r = {TK_LITERAL, TK_OR};
			CH_SLASH: r = {TK_DIV, TK_LITERAL};
			default: r = {TK_GT, TK_GE};
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/source_line_tokenizer.sv]
// source_line_tokenizer: top level of the streaming source tokenizer.
// Depends on slt_pkg, slt_front, slt_queue and slt_back.

// One input item (a source byte or an end-of-line mark) is taken every clock
// while in_ready is high; a token leaves one per clock while out_ready is high,
// with last set on the final token an item causes. An item yields zero, one or two
// tokens; its first token passes the queue and the output register. The front part
// classifies items combinationally and puts their tokens into a four-entry queue;
// in_ready drops only while that queue is full, which happens when items produce
// two tokens each for long stretches or the output side stalls.

module source_line_tokenizer #(
	parameter int MAX_COLUMN = slt_pkg::MAX_COLUMN_DEFAULT,
	parameter int MAX_LINE   = slt_pkg::MAX_LINE_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  character,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  token_kind,
	output logic [1:0]  error_code,
	output logic [7:0]  bad_character,
	output logic [15:0] line_number,
	output logic [9:0]  location_column,
	output logic [9:0]  start_column,
	output logic [9:0]  token_length,
	output logic        last
);

	logic             accept, push, pop, full;
	slt_pkg::bundle_t bundle;
	slt_pkg::qhead_t  head;
	slt_pkg::tok_t    tok;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	slt_front #(
		.MAX_COLUMN (MAX_COLUMN),
		.MAX_LINE   (MAX_LINE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (action),
		.character (character),
		.push      (push),
		.bundle    (bundle)
	);

	slt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (bundle),
		.pop    (pop),
		.full   (full),
		.head   (head)
	);

	slt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tok       (tok),
		.last      (last)
	);

	assign token_kind      = tok.kind;
	assign error_code      = tok.err;
	assign bad_character   = tok.bad;
	assign line_number     = tok.line;
	assign location_column = tok.loc;
	assign start_column    = tok.start;
	assign token_length    = tok.len;

endmodule

[hw/rtl/slt_front.sv]
// slt_front: per-byte classification, line/column tracking and pending token
// resolution; produces up to two tokens per item. Depends on slt_pkg.

module slt_front #(
	parameter int MAX_COLUMN = slt_pkg::MAX_COLUMN_DEFAULT,
	parameter int MAX_LINE   = slt_pkg::MAX_LINE_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              action,
	input  logic [7:0]        character,
	output logic              push,
	output slt_pkg::bundle_t  bundle
);

	localparam int CW = $clog2(MAX_COLUMN + 1);
	localparam int LW = $clog2(MAX_LINE + 1);

	logic [LW-1:0]          line_q, line_d;
	logic [CW-1:0]          col_q, col_d;
	slt_pkg::pend_class_t   pcls_q, pcls_d;
	logic [7:0]             pop_q, pop_d;
	logic [CW-1:0]          tstart_q, tstart_d;
	logic [39:0]            prefix_q, prefix_d;
	logic [9:0]             wlen_q, wlen_d;
	logic                   skip_q, skip_d;

	function automatic logic [9:0] col_out(input logic [CW-1:0] x);
		logic [CW+9:0] wide;
		wide = {10'd0, x};
		return wide[9:0];
	endfunction

	function automatic logic [15:0] line_out(input logic [LW-1:0] x);
		logic [LW+15:0] wide;
		wide = {16'd0, x};
		return wide[15:0];
	endfunction

	function automatic logic [CW-1:0] col_inc(input logic [CW-1:0] x);
		return (x == CW'(MAX_COLUMN)) ? x : x + 1'b1;
	endfunction

	logic       c_digit, c_alpha, c_space, c_wstart, c_word, c_opst;
	logic [4:0] c_single;
	logic [9:0] op_k;
	logic       op_slash, op_pair, op_match;
	logic       ext, num_err, op_cons;
	logic [LW-1:0] line_inc;

	assign c_digit  = slt_pkg::is_digit(character);
	assign c_alpha  = slt_pkg::is_alpha(character);
	assign c_space  = slt_pkg::is_space(character);
	assign c_wstart = c_alpha || character == slt_pkg::CH_UNDER;
	assign c_word   = c_wstart || c_digit;
	assign c_opst   = slt_pkg::is_op_start(character);
	assign c_single = slt_pkg::single_kind(character);
	assign op_k     = slt_pkg::op_kinds(pop_q);

	assign op_slash = pop_q == slt_pkg::CH_SLASH;
	assign op_pair  = pop_q == slt_pkg::CH_AMP || pop_q == slt_pkg::CH_PIPE;
	assign op_match = !action && (op_slash ? character == slt_pkg::CH_SLASH :
		op_pair ? character == pop_q : character == slt_pkg::CH_EQ);

	assign ext = !action && ((pcls_q == slt_pkg::PC_WORD && c_word) ||
		(pcls_q == slt_pkg::PC_NUM && c_digit));
	assign num_err = !action && pcls_q == slt_pkg::PC_NUM && c_alpha;
	assign op_cons = pcls_q == slt_pkg::PC_OP && (op_pair || op_match);

	assign line_inc = (line_q == LW'(MAX_LINE)) ? line_q : line_q + 1'b1;

	slt_pkg::tok_t pend, fresh;
	logic          pend_valid, fresh_valid, pv, fv;

	always_comb begin
		pend       = '0;
		pend.line  = line_out(line_q);
		pend.start = col_out(tstart_q);
		pend_valid = 1'b0;
		unique case (pcls_q)
			slt_pkg::PC_NONE: begin
				pend_valid = 1'b0;
			end
			slt_pkg::PC_WORD: begin
				pend_valid = !ext;
				pend.kind  = slt_pkg::keyword_kind(prefix_q, wlen_q);
				pend.loc   = col_out(col_q);
				pend.len   = wlen_q;
			end
			slt_pkg::PC_NUM: begin
				pend_valid = !ext;
				pend.kind  = slt_pkg::TK_LITERAL;
				pend.err   = num_err ? slt_pkg::ERR_DIGIT_ALPHA : slt_pkg::ERR_NONE;
				pend.loc   = col_out(col_q);
				pend.len   = wlen_q;
			end
			slt_pkg::PC_OP: begin
				pend.loc = col_out(col_inc(tstart_q));
				if (op_slash) begin
					pend_valid = !op_match;
					pend.kind  = op_k[9:5];
					pend.len   = 10'd1;
				end else if (op_pair && !op_match) begin
					pend_valid = 1'b1;
					pend.kind  = slt_pkg::TK_LITERAL;
					pend.err   = slt_pkg::ERR_BAD_CHAR;
					pend.bad   = pop_q;
					pend.len   = 10'd1;
				end else begin
					pend_valid = 1'b1;
					pend.kind  = op_match ? op_k[4:0] : op_k[9:5];
					pend.len   = op_match ? 10'd2 : 10'd1;
				end
			end
		endcase
	end

	always_comb begin
		fresh       = '0;
		fresh.line  = line_out(line_q);
		fresh.loc   = col_out(col_inc(col_q));
		fresh.start = col_out(col_q);
		fresh.len   = 10'd1;
		if (c_single != slt_pkg::TK_LITERAL) begin
			fresh.kind = c_single;
		end else begin
			fresh.err = slt_pkg::ERR_BAD_CHAR;
			fresh.bad = character;
		end
		fresh_valid = !action && !ext && !num_err && !op_cons && !c_space && !c_digit &&
			!c_wstart && !c_opst;
	end

	assign pv = !skip_q && pend_valid;
	assign fv = !skip_q && fresh_valid;

	assign push          = accept && (pv || fv);
	assign bundle.two    = pv && fv;
	assign bundle.first  = pv ? pend : fresh;
	assign bundle.second = fresh;

	always_comb begin
		line_d   = line_q;
		col_d    = col_q;
		pcls_d   = pcls_q;
		pop_d    = pop_q;
		tstart_d = tstart_q;
		prefix_d = prefix_q;
		wlen_d   = wlen_q;
		skip_d   = skip_q;
		if (accept) begin
			if (action) begin
				pcls_d   = slt_pkg::PC_NONE;
				pop_d    = '0;
				tstart_d = '0;
				prefix_d = '0;
				wlen_d   = '0;
				skip_d   = 1'b0;
				line_d   = line_inc;
				col_d    = '0;
			end else if (!skip_q) begin
				if (ext) begin
					if (pcls_q == slt_pkg::PC_WORD && wlen_q < 10'd5) begin
						prefix_d = prefix_q | ({32'd0, character} << {wlen_q[2:0], 3'b000});
					end
					if (wlen_q != slt_pkg::LEN_CAP) wlen_d = wlen_q + 10'd1;
					col_d = col_inc(col_q);
				end else if (num_err) begin
					pcls_d = slt_pkg::PC_NONE;
					skip_d = 1'b1;
				end else if (op_cons) begin
					pcls_d = slt_pkg::PC_NONE;
					if (op_match && !op_slash) col_d = col_inc(col_q);
					else skip_d = 1'b1;
				end else begin
					pcls_d = slt_pkg::PC_NONE;
					if (c_space) begin
						if (character == slt_pkg::CH_NL) begin
							line_d = line_inc;
							col_d  = '0;
						end else begin
							col_d = col_inc(col_q);
						end
					end else if (c_digit) begin
						pcls_d   = slt_pkg::PC_NUM;
						tstart_d = col_q;
						wlen_d   = 10'd1;
						col_d    = col_inc(col_q);
					end else if (c_wstart) begin
						pcls_d   = slt_pkg::PC_WORD;
						tstart_d = col_q;
						wlen_d   = 10'd1;
						prefix_d = {32'd0, character};
						col_d    = col_inc(col_q);
					end else if (c_opst) begin
						pcls_d   = slt_pkg::PC_OP;
						pop_d    = character;
						tstart_d = col_q;
						col_d    = col_inc(col_q);
					end else begin
						skip_d = c_single == slt_pkg::TK_LITERAL;
						col_d  = col_inc(col_q);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= '0;
			col_q    <= '0;
			pcls_q   <= slt_pkg::PC_NONE;
			pop_q    <= '0;
			tstart_q <= '0;
			prefix_q <= '0;
			wlen_q   <= '0;
			skip_q   <= 1'b0;
		end else begin
			line_q   <= line_d;
			col_q    <= col_d;
			pcls_q   <= pcls_d;
			pop_q    <= pop_d;
			tstart_q <= tstart_d;
			prefix_q <= prefix_d;
			wlen_q   <= wlen_d;
			skip_q   <= skip_d;
		end
	end

`ifndef SYNTH
	a_skip_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> pcls_q == slt_pkg::PC_NONE)
		else $error("pending token held while skipping");
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tstart_q <= col_q || pcls_q == slt_pkg::PC_NONE)
		else $error("token start beyond column");
`endif

endmodule

[hw/rtl/slt_queue.sv]
// slt_queue: short queue of token bundles between the front and back parts.
// Depends on slt_pkg.

module slt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  slt_pkg::bundle_t  din,
	input  logic              pop,
	output logic              full,
	output slt_pkg::qhead_t   head
);

	localparam int DEPTH = slt_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	slt_pkg::bundle_t mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [NW-1:0]    cnt_q;

	assign full        = cnt_q == NW'(DEPTH);
	assign head.avail  = cnt_q != '0;
	assign head.bundle = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.avail)
		else $error("pop from empty queue");
`endif

endmodule

[hw/rtl/slt_back.sv]
// slt_back: serializes queued bundles into single tokens through an output
// register. Depends on slt_pkg.

module slt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  slt_pkg::qhead_t  head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output slt_pkg::tok_t    tok,
	output logic             last
);

	logic          valid_q, sel_q, last_q;
	slt_pkg::tok_t tok_q;
	logic          load, cur_last;

	assign load     = head.avail && (!valid_q || out_ready);
	assign cur_last = sel_q || !head.bundle.two;
	assign pop      = load && cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (!valid_q || out_ready) valid_q <= head.avail;
			if (load) sel_q <= !cur_last;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= sel_q ? head.bundle.second : head.bundle.first;
			last_q <= cur_last;
		end
	end

	assign out_valid = valid_q;
	assign tok       = tok_q;
	assign last      = last_q;

`ifndef SYNTH
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_ready && !last_q |=> valid_q)
		else $error("second token of item did not follow");
`endif

endmodule
